[hw/rtl/qte_pkg.sv]
// Package: shared widths, constants, arctangent table for quaternion to Euler core
package qte_pkg;

  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_TAB_LEN = 24;
  localparam int unsigned N_STEPS = (CORDIC_STEPS < ATAN_TAB_LEN) ? CORDIC_STEPS : ATAN_TAB_LEN;
  localparam int unsigned SQRT_BITS = 31;  // result bits of the square root
  localparam int unsigned SQRT_W = 62;     // radicand width (2^61 max)

  // Datapath widths: CORDIC x/y grow by about 1.65x, keep 36 bits.
  localparam int unsigned XY_W = 36;
  localparam int unsigned Z_W = 34;

  typedef logic signed [15:0] q15_t;
  typedef logic signed [XY_W-1:0] xy_t;
  typedef logic signed [Z_W-1:0] ang_t;

  localparam ang_t PI_ANG = ang_t'(64'sh80000000);
  localparam ang_t HALF_PI_ANG = ang_t'(64'sh40000000);
  localparam xy_t ONE_Q30 = xy_t'(64'sh40000000);

  function automatic ang_t atan_tab(input int unsigned i);
    ang_t r;
    case (i)
      0: r = ang_t'(32'h20000000);
      1: r = ang_t'(32'h12E4051E);
      2: r = ang_t'(32'h09FB385B);
      3: r = ang_t'(32'h051111D4);
      4: r = ang_t'(32'h028B0D43);
      5: r = ang_t'(32'h0145D7E1);
      6: r = ang_t'(32'h00A2F61E);
      7: r = ang_t'(32'h00517C55);
      8: r = ang_t'(32'h0028BE53);
      9: r = ang_t'(32'h00145F2F);
      10: r = ang_t'(32'h000A2F98);
      11: r = ang_t'(32'h000517CC);
      12: r = ang_t'(32'h00028BE6);
      13: r = ang_t'(32'h000145F3);
      14: r = ang_t'(32'h0000A2FA);
      15: r = ang_t'(32'h0000517D);
      16: r = ang_t'(32'h000028BE);
      17: r = ang_t'(32'h0000145F);
      18: r = ang_t'(32'h00000A30);
      19: r = ang_t'(32'h00000518);
      20: r = ang_t'(32'h0000028C);
      21: r = ang_t'(32'h00000146);
      22: r = ang_t'(32'h000000A3);
      23: r = ang_t'(32'h00000051);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Round half up from pi/2^31 units to pi/2^15 units
  function automatic logic signed [Z_W-16:0] round_ang(input ang_t a);
    ang_t s;
    s = a + ang_t'(32'h8000);
    return $signed(s[Z_W-1:15]) >>> 1;
  endfunction

endpackage

[hw/rtl/qte_if.sv]
// Interfaces: quaternion request channel and Euler angle result channel
interface qte_quat_if;
  import qte_pkg::*;
  logic valid;
  logic ready;
  q15_t quat_w;
  q15_t quat_x;
  q15_t quat_y;
  q15_t quat_z;
  modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qte_euler_if;
  import qte_pkg::*;
  logic valid;
  logic ready;
  q15_t roll_angle;
  q15_t pitch_angle;
  q15_t yaw_angle;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, output ready);
endinterface

[hw/rtl/qte_terms.sv]
// Product terms: three pipeline stages from quaternion to atan2 arguments and t
module qte_terms import qte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  q15_t w,
  input  q15_t x,
  input  q15_t y,
  input  q15_t z,
  output logic out_valid,
  output xy_t  sr,
  output xy_t  cr,
  output xy_t  sy,
  output xy_t  cy,
  output logic [SQRT_W-1:0] rad_p,  // (1+t) << 30
  output logic [SQRT_W-1:0] rad_m   // (1-t) << 30
);
  // stage 1: products
  logic signed [31:0] wx, yz, xx, yy, zz, wy, xz, wz, xy;
  logic v1;
  // stage 2: sums
  logic v2;
  logic signed [33:0] t2;
  xy_t sr2, cr2, sy2, cy2;
  logic signed [33:0] tc;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_comb begin
    tc = t2;
    if (t2 > 34'sh40000000) tc = 34'sh40000000;
    if (t2 < -34'sh40000000) tc = -34'sh40000000;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wx <= w * x; yz <= y * z; xx <= x * x; yy <= y * y; zz <= z * z;
      wy <= w * y; xz <= x * z; wz <= w * z; xy <= x * y;
      sr2 <= xy_t'(wx) + xy_t'(yz) <<< 1;
      cr2 <= ONE_Q30 - ((xy_t'(xx) + xy_t'(yy)) <<< 1);
      sy2 <= (xy_t'(wz) + xy_t'(xy)) <<< 1;
      cy2 <= ONE_Q30 - ((xy_t'(yy) + xy_t'(zz)) <<< 1);
      t2 <= (34'(wy) - 34'(xz)) <<< 1;
      sr <= sr2; cr <= cr2; sy <= sy2; cy <= cy2;
      rad_p <= SQRT_W'(unsigned'(34'sh40000000 + tc)) << 30;
      rad_m <= SQRT_W'(unsigned'(34'sh40000000 - tc)) << 30;
    end
  end
endmodule

[hw/rtl/qte_sqrt.sv]
// Pipelined restoring integer square root, one result bit per step, a register after every fourth step
module qte_sqrt import qte_pkg::*; (
  input  logic clk,
  input  logic en,
  input  logic [SQRT_W-1:0] rad,
  output logic [SQRT_BITS-1:0] root
);
  logic [SQRT_W:0] rem [SQRT_BITS+1];
  logic [SQRT_BITS-1:0] q [SQRT_BITS+1];

  assign rem[0] = {1'b0, rad};
  assign q[0] = '0;

  for (genvar i = 0; i < SQRT_BITS; i++) begin : g_st
    localparam int unsigned B = SQRT_BITS - 1 - i;
    logic [SQRT_W:0] trial;
    logic [SQRT_W:0] rem_n;
    logic [SQRT_BITS-1:0] q_n;
    always_comb begin
      trial = ((SQRT_W+1)'(q[i]) << (B + 1)) | ((SQRT_W+1)'(1) << (2 * B));
      if (rem[i] >= trial) begin
        rem_n = rem[i] - trial;
        q_n = q[i] | (SQRT_BITS'(1) << B);
      end else begin
        rem_n = rem[i];
        q_n = q[i];
      end
    end
    if (i % 4 == 3) begin : g_reg
      logic [SQRT_W:0] rr;
      logic [SQRT_BITS-1:0] qr;
      always_ff @(posedge clk) if (en) begin
        rr <= rem_n;
        qr <= q_n;
      end
      assign rem[i+1] = rr;
      assign q[i+1] = qr;
    end else begin : g_cmb
      assign rem[i+1] = rem_n;
      assign q[i+1] = q_n;
    end
  end
  assign root = q[SQRT_BITS];
endmodule

[hw/rtl/qte_cordic.sv]
// Vectoring CORDIC arctangent, one micro-rotation per pipeline stage
module qte_cordic import qte_pkg::*; (
  input  logic clk,
  input  logic en,
  input  xy_t  y_in,
  input  xy_t  x_in,
  output ang_t z_out
);
  xy_t  xs [N_STEPS+1];
  xy_t  ys [N_STEPS+1];
  ang_t zs [N_STEPS+1];
  logic zero [N_STEPS+1];

  // prerotation into the right half plane
  always_ff @(posedge clk) if (en) begin
    zero[0] <= (x_in == '0) && (y_in == '0);
    if (x_in < 0) begin
      xs[0] <= -x_in;
      ys[0] <= -y_in;
      zs[0] <= (y_in >= 0) ? PI_ANG : -PI_ANG;
    end else begin
      xs[0] <= x_in;
      ys[0] <= y_in;
      zs[0] <= '0;
    end
  end

  for (genvar i = 0; i < N_STEPS; i++) begin : g_it
    always_ff @(posedge clk) if (en) begin
      zero[i+1] <= zero[i];
      if (ys[i] >= 0) begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + atan_tab(i);
      end else begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - atan_tab(i);
      end
    end
  end
  assign z_out = zero[N_STEPS] ? '0 : zs[N_STEPS];
endmodule

[hw/rtl/quaternion_to_euler_angles_core.sv]
// Quaternion (Q1.15) to z-y-x Euler binary angles, fully pipelined core
// Throughput: one request per cycle while the output is not held; back-to-back with no bubbles.
// Pipeline: 3 product stages + 7 square-root stages + 17 CORDIC stages + 1 output
//   register = 28 register stages; the CORDIC chain length sets most of it.
// The whole pipe advances together; it freezes only while the output is held.
// Reset (rst, synchronous) clears all valid bits; payload registers are not reset.
module quaternion_to_euler_angles_core import qte_pkg::*; (
  input logic clk,
  input logic rst,
  qte_quat_if.sink in_ch,
  qte_euler_if.source out_ch
);
  // Pipeline depth from term outputs to CORDIC result
  localparam int unsigned SQRT_LAT = SQRT_BITS / 4;
  localparam int unsigned CORD_LAT = N_STEPS + 1;
  localparam int unsigned MID_LAT = SQRT_LAT + CORD_LAT;

  // Global enable: move when the output slot is empty or being taken
  logic en;
  assign en = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  logic t_valid;
  xy_t sr, cr, sy, cy;
  logic [SQRT_W-1:0] rad_p, rad_m;

  qte_terms u_terms (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_ch.valid && en),
    .w(in_ch.quat_w), .x(in_ch.quat_x), .y(in_ch.quat_y), .z(in_ch.quat_z),
    .out_valid(t_valid), .sr(sr), .cr(cr), .sy(sy), .cy(cy),
    .rad_p(rad_p), .rad_m(rad_m)
  );

  // Pitch branch: two square roots, then atan2
  logic [SQRT_BITS-1:0] sp, cp;
  qte_sqrt u_sqrt_p (.clk(clk), .en(en), .rad(rad_p), .root(sp));
  qte_sqrt u_sqrt_m (.clk(clk), .en(en), .rad(rad_m), .root(cp));

  // Roll and yaw arguments are delayed to line up with the square roots
  xy_t sr_d [SQRT_LAT+1];
  xy_t cr_d [SQRT_LAT+1];
  xy_t sy_d [SQRT_LAT+1];
  xy_t cy_d [SQRT_LAT+1];
  assign sr_d[0] = sr;
  assign cr_d[0] = cr;
  assign sy_d[0] = sy;
  assign cy_d[0] = cy;
  for (genvar k = 0; k < SQRT_LAT; k++) begin : g_dly
    always_ff @(posedge clk) if (en) begin
      sr_d[k+1] <= sr_d[k];
      cr_d[k+1] <= cr_d[k];
      sy_d[k+1] <= sy_d[k];
      cy_d[k+1] <= cy_d[k];
    end
  end

  ang_t z_roll, z_pitch, z_yaw;
  qte_cordic u_cord_r (.clk(clk), .en(en), .y_in(sr_d[SQRT_LAT]),
                       .x_in(cr_d[SQRT_LAT]), .z_out(z_roll));
  qte_cordic u_cord_p (.clk(clk), .en(en), .y_in(xy_t'(sp)), .x_in(xy_t'(cp)),
                       .z_out(z_pitch));
  qte_cordic u_cord_y (.clk(clk), .en(en), .y_in(sy_d[SQRT_LAT]),
                       .x_in(cy_d[SQRT_LAT]), .z_out(z_yaw));

  // Valid bits travel alongside the data
  logic [MID_LAT-1:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst) vpipe <= '0;
    else if (en) vpipe <= {vpipe[MID_LAT-2:0], t_valid};
  end

  // Final rounding; pitch is 2*z - pi/2, clamped to +-pi/2
  ang_t pz;
  logic signed [Z_W-16:0] pr;
  logic signed [Z_W-16:0] rr, yr;
  q15_t pitch_sat;
  always_comb begin
    pz = (z_pitch <<< 1) - HALF_PI_ANG;
    pr = round_ang(pz);
    rr = round_ang(z_roll);
    yr = round_ang(z_yaw);
    if (pr > 19'sd16384) pitch_sat = 16'sd16384;
    else if (pr < -19'sd16384) pitch_sat = -16'sd16384;
    else pitch_sat = q15_t'(pr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (en) begin
      out_ch.valid <= vpipe[MID_LAT-1];
    end
  end
  always_ff @(posedge clk) if (en) begin
    out_ch.roll_angle <= q15_t'(rr);
    out_ch.pitch_angle <= pitch_sat;
    out_ch.yaw_angle <= q15_t'(yr);
  end

  // Pitch never leaves the quarter turn
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.pitch_angle <= 16'sd16384 && out_ch.pitch_angle >= -16'sd16384))
    else $error("pitch out of range");
  // Ready follows the output slot
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("accepted while stalled");
  // A held result is not replaced
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.yaw_angle)))
    else $error("result lost under stall");
endmodule
